>>> rtl/ptam_pkg.sv
`timescale 1ns / 1ps
package ptam_pkg;

  // Fixed-point format of inputs and outputs
  localparam int FRAC_BITS = 30;
  localparam int IN_W      = 32;
  localparam int OUT_W     = 31;

  // Chord lengths: component differences, squares, sums
  localparam int D_W    = IN_W + 1;
  localparam int DSQ_W  = 2 * D_W;
  localparam int L_W    = IN_W + 1;
  localparam int LSQ_W  = 2 * L_W;
  localparam int SSQ_W  = LSQ_W + 2;
  localparam int SQH_W  = SSQ_W / 2;

  // Heron product: perimeter and the running product widths
  localparam int P_W    = L_W + 2;
  localparam int H1_W   = 2 * P_W;
  localparam int H2_W   = 3 * P_W;
  localparam int H3_W   = 4 * P_W;
  localparam int HS_W   = H3_W - 2 * FRAC_BITS - 4;
  localparam int AREA_W = (HS_W + 1) / 2;

  // Shared integer square root datapath width
  localparam int SQ_ROOT_W = (AREA_W > L_W) ? AREA_W : L_W;
  localparam int SQ_REM_W  = 2 * SQ_ROOT_W;

  // Moment: area times sum of squares, then divide by 36
  localparam int QP_W  = AREA_W + SQH_W;
  localparam int T_W   = AREA_W + SSQ_W;
  localparam int XS_W  = T_W - 2 * FRAC_BITS;
  localparam int XE_W  = (XS_W > 38) ? XS_W : 38;
  localparam int Y_W   = 35;
  localparam int REC_K = 38;
  localparam int REC_W = 35;
  localparam int PR_W  = Y_W + REC_W;
  localparam int Q_W   = PR_W - REC_K;
  localparam int DIV_C = 9;

  localparam logic [REC_W-1:0] REC_M   = REC_W'((64'd1 << REC_K) / 64'd9);
  localparam logic [XE_W-1:0]  SAT_X   = XE_W'(36) << 31;
  localparam logic [OUT_W-1:0] OUT_MAX = {OUT_W{1'b1}};

  typedef struct packed {
    logic signed [IN_W-1:0] a_x;
    logic signed [IN_W-1:0] a_y;
    logic signed [IN_W-1:0] a_z;
    logic signed [IN_W-1:0] b_x;
    logic signed [IN_W-1:0] b_y;
    logic signed [IN_W-1:0] b_z;
    logic signed [IN_W-1:0] c_x;
    logic signed [IN_W-1:0] c_y;
    logic signed [IN_W-1:0] c_z;
  } ptam_in_t;

  typedef struct packed {
    logic [OUT_W-1:0] area;
    logic [OUT_W-1:0] polar_moment;
  } ptam_out_t;

  // Square root iteration state: remainder (value - root^2) and partial root
  typedef struct packed {
    logic [SQ_REM_W-1:0]  rem;
    logic [SQ_ROOT_W-1:0] root;
  } isq_t;

  // One restoring square root step deciding root bit b
  function automatic isq_t isq_step(isq_t s, int b);
    logic [SQ_REM_W:0] trial;
    isq_t r;
    trial = ((SQ_REM_W + 1)'(s.root) << (b + 1)) + ((SQ_REM_W + 1)'(1) << (2 * b));
    r = s;
    if (trial <= {1'b0, s.rem}) begin
      r.rem  = s.rem - trial[SQ_REM_W-1:0];
      r.root = s.root | (SQ_ROOT_W'(1) << b);
    end
    return r;
  endfunction

endpackage

>>> rtl/planar_triangle_area_moment_core.sv
`timescale 1ns / 1ps
// Planar triangle area and polar moment of three star direction vectors.
// Input channel vtx (vtx_valid / vtx_stall) carries one beat per triangle:
// nine signed Q2.30 components of stars A, B and C. Output channel res
// (res_valid / res_stall) returns one beat per triangle: area and polar
// moment, unsigned Q1.30, saturated at 2^31-1.
// Pipeline: a beat accepted on vtx passes through 3 difference/square
// stages, 33 chord root stages, 7 Heron stages, 38 area root stages and
// 6 moment/divide stages before it leaves on res. The two bit-serial
// square roots, one stage per root bit, set that depth.
// Throughput: one triangle per cycle when not stalled; stages move together.
// Reset clears all stage valid bits; no beat is in flight afterward.
// When res_stall is high with a beat waiting, the whole pipeline freezes
// and vtx_stall is raised in the same cycle; nothing is dropped or repeated.
// Results come out in the order the triangles went in.
module planar_triangle_area_moment_core (
  input  logic                clk,
  input  logic                rst,
  input  logic                vtx_valid,
  output logic                vtx_stall,
  input  ptam_pkg::ptam_in_t  vtx,
  output logic                res_valid,
  input  logic                res_stall,
  output ptam_pkg::ptam_out_t res
);
  import ptam_pkg::*;

  localparam int CH_N  = L_W;
  localparam int AR_N  = AREA_W;
  localparam int N_ST  = 3 + CH_N + 7 + AR_N + 6;
  localparam int ST_S9 = 3 + CH_N + 5;
  localparam int ST_S15 = N_ST - 2;
  localparam int NXT [0:2] = '{1, 2, 0};

  logic adv;
  logic [N_ST-1:0] vld;

  // Global advance: frozen only while a result beat waits on a stall
  assign adv       = !(res_valid && res_stall);
  assign vtx_stall = !adv;
  assign res_valid = vld[N_ST-1];

  // Valid bits travel with the data
  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[N_ST-2:0], vtx_valid};
    end
  end

  // S1: absolute component differences for chords AB, BC, CA
  logic signed [IN_W-1:0] pt [0:2][0:2];
  logic [D_W-1:0] dabs [0:2][0:2];
  logic [D_W-1:0] s1_d [0:2][0:2];

  always_comb begin
    logic [D_W-1:0] dif;
    pt[0][0] = vtx.a_x; pt[0][1] = vtx.a_y; pt[0][2] = vtx.a_z;
    pt[1][0] = vtx.b_x; pt[1][1] = vtx.b_y; pt[1][2] = vtx.b_z;
    pt[2][0] = vtx.c_x; pt[2][1] = vtx.c_y; pt[2][2] = vtx.c_z;
    dif = '0;
    for (int i = 0; i < 3; i++) begin
      for (int k = 0; k < 3; k++) begin
        dif = {pt[i][k][IN_W-1], pt[i][k]} - {pt[NXT[i]][k][IN_W-1], pt[NXT[i]][k]};
        dabs[i][k] = dif[D_W-1] ? (~dif + D_W'(1)) : dif;
      end
    end
  end

  // S2: squares, S3: sum per chord into the root pipeline
  logic [DSQ_W-1:0] s2_sq [0:2][0:2];
  isq_t cst [0:CH_N][0:2];

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_d <= dabs;
      for (int i = 0; i < 3; i++) begin
        for (int k = 0; k < 3; k++) begin
          s2_sq[i][k] <= DSQ_W'(s1_d[i][k]) * DSQ_W'(s1_d[i][k]);
        end
        cst[0][i].rem  <= SQ_REM_W'(s2_sq[i][0]) + SQ_REM_W'(s2_sq[i][1])
                        + SQ_REM_W'(s2_sq[i][2]);
        cst[0][i].root <= '0;
      end
    end
  end

  // Chord roots, one bit per stage, three lanes
  for (genvar k = 0; k < CH_N; k++) begin : g_chord
    always_ff @(posedge clk) begin
      if (adv) begin
        for (int i = 0; i < 3; i++) begin
          cst[k+1][i] <= isq_step(cst[k][i], CH_N - 1 - k);
        end
      end
    end
  end

  // S4..S10: perimeter, Heron factors, product chain, sum of squares
  logic [L_W-1:0]   s4_len [0:2];
  logic [P_W-1:0]   s4_p;
  logic [P_W-1:0]   s5_p;
  logic [P_W-1:0]   s5_f [0:2];
  logic [LSQ_W-1:0] s5_lsq [0:2];
  logic             s5_bad;
  logic             bad_next;
  logic [H1_W-1:0]  s6_p1;
  logic [P_W-1:0]   s6_f1, s6_f2;
  logic             s6_bad;
  logic [SSQ_W-1:0] s6_ssq;
  logic [H1_W-1:0]  s7_r [0:1];
  logic [P_W-1:0]   s7_f2;
  logic             s7_bad;
  logic [SSQ_W-1:0] s7_ssq;
  logic [H2_W-1:0]  s8_h2;
  logic [P_W-1:0]   s8_f2;
  logic             s8_bad;
  logic [SSQ_W-1:0] s8_ssq;
  logic [H1_W-1:0]  s9_r [0:2];
  logic             s9_bad;
  logic [SSQ_W-1:0] s9_ssq;
  logic [H3_W-1:0]  h3;
  isq_t             ast [0:AR_N];
  logic [SSQ_W-1:0] assq [0:AR_N];

  // Triangle inequality broken by truncated lengths
  always_comb begin
    bad_next = 1'b0;
    for (int i = 0; i < 3; i++) begin
      if (P_W'({s4_len[i], 1'b0}) > s4_p) begin
        bad_next = 1'b1;
      end
    end
  end

  assign h3 = H3_W'(s9_r[0]) + (H3_W'(s9_r[1]) << P_W) + (H3_W'(s9_r[2]) << (2 * P_W));

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 3; i++) begin
        s4_len[i] <= cst[CH_N][i].root[L_W-1:0];
      end
      s4_p <= P_W'(cst[CH_N][0].root[L_W-1:0]) + P_W'(cst[CH_N][1].root[L_W-1:0])
            + P_W'(cst[CH_N][2].root[L_W-1:0]);
      // S5
      s5_p   <= s4_p;
      s5_bad <= bad_next;
      for (int i = 0; i < 3; i++) begin
        s5_f[i]   <= s4_p - P_W'({s4_len[i], 1'b0});
        s5_lsq[i] <= LSQ_W'(s4_len[i]) * LSQ_W'(s4_len[i]);
      end
      // S6
      s6_p1  <= H1_W'(s5_p) * H1_W'(s5_f[0]);
      s6_f1  <= s5_f[1];
      s6_f2  <= s5_f[2];
      s6_bad <= s5_bad;
      s6_ssq <= SSQ_W'(s5_lsq[0]) + SSQ_W'(s5_lsq[1]) + SSQ_W'(s5_lsq[2]);
      // S7: partial products of the second factor
      s7_r[0] <= H1_W'(s6_p1[P_W-1:0]) * H1_W'(s6_f1);
      s7_r[1] <= H1_W'(s6_p1[2*P_W-1:P_W]) * H1_W'(s6_f1);
      s7_f2   <= s6_f2;
      s7_bad  <= s6_bad;
      s7_ssq  <= s6_ssq;
      // S8
      s8_h2  <= H2_W'(s7_r[0]) + (H2_W'(s7_r[1]) << P_W);
      s8_f2  <= s7_f2;
      s8_bad <= s7_bad;
      s8_ssq <= s7_ssq;
      // S9: partial products of the third factor
      for (int j = 0; j < 3; j++) begin
        s9_r[j] <= H1_W'(s8_h2[j*P_W +: P_W]) * H1_W'(s8_f2);
      end
      s9_bad <= s8_bad;
      s9_ssq <= s8_ssq;
      // S10: 16*area^2 scaled down to area^2, zero when not a triangle
      ast[0].rem  <= s9_bad ? '0 : SQ_REM_W'(h3 >> (2 * FRAC_BITS + 4));
      ast[0].root <= '0;
      assq[0]     <= s9_ssq;
    end
  end

  // Area root, one bit per stage
  for (genvar k = 0; k < AR_N; k++) begin : g_area
    always_ff @(posedge clk) begin
      if (adv) begin
        ast[k+1]  <= isq_step(ast[k], AR_N - 1 - k);
        assq[k+1] <= assq[k];
      end
    end
  end

  // S11..S16: moment = area * ssq / 36, with reciprocal divide by 9
  logic [AREA_W-1:0] ar;
  logic [QP_W-1:0]   s11_q [0:1];
  logic [OUT_W-1:0]  s11_area, s12_area, s13_area, s14_area, s15_area;
  logic [T_W-1:0]    t12;
  logic [XE_W-1:0]   s12_x;
  logic              s13_sat, s14_sat, s15_sat;
  logic [Y_W-1:0]    s13_y, s14_y;
  logic [PR_W-1:0]   s14_pr;
  logic [Q_W-1:0]    qe;
  logic [Q_W-1:0]    s15_q;
  logic [Y_W-1:0]    s15_r;

  assign ar  = ast[AR_N].root[AREA_W-1:0];
  assign t12 = T_W'(s11_q[0]) + (T_W'(s11_q[1]) << SQH_W);
  assign qe  = s14_pr[PR_W-1:REC_K];

  always_ff @(posedge clk) begin
    if (adv) begin
      // S11
      s11_q[0] <= QP_W'(ar) * QP_W'(assq[AR_N][SQH_W-1:0]);
      s11_q[1] <= QP_W'(ar) * QP_W'(assq[AR_N][SSQ_W-1:SQH_W]);
      s11_area <= ((ar >> OUT_W) != '0) ? OUT_MAX : OUT_W'(ar);
      // S12
      s12_x    <= XE_W'(t12 >> (2 * FRAC_BITS));
      s12_area <= s11_area;
      // S13: saturation test, then x / 4
      s13_sat  <= s12_x >= SAT_X;
      s13_y    <= Y_W'(s12_x >> 2);
      s13_area <= s12_area;
      // S14: reciprocal product
      s14_pr   <= PR_W'(s13_y) * PR_W'(REC_M);
      s14_y    <= s13_y;
      s14_sat  <= s13_sat;
      s14_area <= s13_area;
      // S15: estimate and its remainder
      s15_q    <= qe;
      s15_r    <= s14_y - ((Y_W'(qe) << 3) + Y_W'(qe));
      s15_sat  <= s14_sat;
      s15_area <= s14_area;
      // S16: correct estimate, output register
      res.area <= s15_area;
      if (s15_sat) begin
        res.polar_moment <= OUT_MAX;
      end else if (s15_r >= Y_W'(DIV_C)) begin
        res.polar_moment <= OUT_W'(s15_q + Q_W'(1));
      end else begin
        res.polar_moment <= OUT_W'(s15_q);
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_zero_area: assert property (@(posedge clk) disable iff (rst)
    res_valid && res.area == '0 |-> res.polar_moment == '0)
    else $error("nonzero moment with zero area");

  a_bad_clears: assert property (@(posedge clk) disable iff (rst)
    adv && vld[ST_S9] && s9_bad |=> ast[0].rem == '0)
    else $error("broken triangle did not clear the area radicand");

  a_div_rem: assert property (@(posedge clk) disable iff (rst)
    vld[ST_S15] |-> s15_r < Y_W'(2 * DIV_C))
    else $error("reciprocal estimate off by more than one");

  a_freeze: assert property (@(posedge clk) disable iff (rst)
    !adv |=> $stable(vld))
    else $error("pipeline moved while frozen");
`endif

endmodule
